// ===== rtl/core/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and constants for the positional list store: operation and
// status codes, field widths and the control word that drives the cell row.
// ----------------------------------------------------------------------------
package plst_pkg;

  // Number of entry cells in the row.
  localparam int CAPACITY = 64;

  // Field widths of the request and result transfers.
  localparam int MODE_W  = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNTO_W  = 7;

  // Internal widths.
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W0  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMP_W   = (CMP_W0 > CNTO_W) ? CMP_W0 : CNTO_W;

  // Read-back reduction: cells are ORed in groups, one register per group.
  localparam int RD_GROUP = 8;
  localparam int NUM_GRP  = (CAPACITY + RD_GROUP - 1) / RD_GROUP;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_SET    = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef logic signed [VAL_W-1:0] value_t;

  // Control word broadcast to every cell for one operation.
  typedef struct packed {
    logic              ins;   // shift up above pos, write value at pos
    logic              rem;   // shift down from pos
    logic              wr;    // overwrite value at pos
    logic [CMP_W-1:0]  pos;
    value_t            val;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/plst_req_if.sv =====
// ----------------------------------------------------------------------------
// plst_req_if
// Request channel: valid/ready handshake carrying mode, position, value_in.
// ----------------------------------------------------------------------------
interface plst_req_if;
  logic                                valid;
  logic                                ready;
  logic [plst_pkg::MODE_W-1:0]         mode;
  logic [plst_pkg::POS_W-1:0]          position;
  logic signed [plst_pkg::VAL_W-1:0]   value_in;

  modport source (output valid, mode, position, value_in, input ready);
  modport sink   (input valid, mode, position, value_in, output ready);
endinterface

// ===== rtl/core/plst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plst_rsp_if
// Result channel: valid/ready handshake carrying value_out, status, count
// and is_empty.
// ----------------------------------------------------------------------------
interface plst_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [plst_pkg::VAL_W-1:0]   value_out;
  logic [plst_pkg::STAT_W-1:0]         status;
  logic [plst_pkg::CNTO_W-1:0]         count;
  logic                                is_empty;

  modport source (output valid, value_out, status, count, is_empty, input ready);
  modport sink   (input valid, value_out, status, count, is_empty, output ready);
endinterface

// ===== rtl/core/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values with insert, remove, get, set, clear.
// ----------------------------------------------------------------------------
// Pipeline: request register (stage A), cell row update with registered
//   read-back groups (stage B), then the result register. A new request is
//   taken once the last has left stage A and stage B is free or emptying.
// Reset: rst (synchronous) empties the list and drops any transfer in flight;
//   entry cells are not cleared, as only entries below the count are read.
// ----------------------------------------------------------------------------
module positional_list_store (
  input  logic        clk,
  input  logic        rst,
  plst_req_if.sink    req,
  plst_rsp_if.source  rsp
);

  // Request register (stage A).
  logic                              req_valid;
  logic [plst_pkg::MODE_W-1:0]       req_mode;
  logic [plst_pkg::POS_W-1:0]        req_pos;
  plst_pkg::value_t                  req_val;

  // Entry count.
  logic [plst_pkg::CNT_W-1:0]        count;
  logic [plst_pkg::CNT_W-1:0]        count_next;

  // Decode stage results.
  plst_pkg::cell_ctrl_t              ctrl;
  plst_pkg::status_t                 status_next;
  logic                              get_ok;

  // Stage B: registered read groups and result fields.
  logic                              s2_valid;
  plst_pkg::status_t                 s2_status;
  logic [plst_pkg::CNT_W-1:0]        s2_count;
  logic                              s2_get;
  plst_pkg::value_t                  grp [plst_pkg::NUM_GRP];
  plst_pkg::value_t                  grp_next [plst_pkg::NUM_GRP];
  plst_pkg::value_t                  rd_all;
  logic                              s2_move;

  // Cell row.
  plst_pkg::value_t                  cell_data [plst_pkg::CAPACITY];
  plst_pkg::value_t                  cell_rd   [plst_pkg::CAPACITY];

  logic [plst_pkg::CMP_W-1:0]        pos_x;
  logic [plst_pkg::CMP_W-1:0]        cnt_x;
  logic [plst_pkg::CMP_W-1:0]        s2_cnt_x;

  // The result register frees stage B when it is empty or being taken.
  assign s2_move   = s2_valid && (!rsp.valid || rsp.ready);
  // Take a new request once the previous one has cleared decode and its
  // result has left or is leaving stage B.
  assign req.ready = !req_valid && (!s2_valid || s2_move);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_valid <= 1'b1;
    end else begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_mode <= req.mode;
      req_pos  <= req.position;
      req_val  <= req.value_in;
    end
  end

  // Decode: range and capacity checks against the current count.
  assign pos_x = plst_pkg::CMP_W'(req_pos);
  assign cnt_x = plst_pkg::CMP_W'(count);

  always_comb begin
    ctrl        = '0;
    ctrl.pos    = pos_x;
    ctrl.val    = req_val;
    status_next = plst_pkg::ST_DONE;
    count_next  = count;
    get_ok      = 1'b0;
    if (req_valid) begin
      unique case (req_mode)
        plst_pkg::MODE_INSERT: begin
          if (pos_x > cnt_x) begin
            status_next = plst_pkg::ST_RANGE;
          end else if (cnt_x == plst_pkg::CMP_W'(plst_pkg::CAPACITY)) begin
            status_next = plst_pkg::ST_FULL;
          end else begin
            ctrl.ins   = 1'b1;
            count_next = count + plst_pkg::CNT_W'(1);
          end
        end
        plst_pkg::MODE_REMOVE: begin
          if (pos_x >= cnt_x) begin
            status_next = plst_pkg::ST_RANGE;
          end else begin
            ctrl.rem   = 1'b1;
            count_next = count - plst_pkg::CNT_W'(1);
          end
        end
        plst_pkg::MODE_GET: begin
          if (pos_x >= cnt_x) begin
            status_next = plst_pkg::ST_RANGE;
          end else begin
            get_ok = 1'b1;
          end
        end
        plst_pkg::MODE_SET: begin
          if (pos_x >= cnt_x) begin
            status_next = plst_pkg::ST_RANGE;
          end else begin
            ctrl.wr = 1'b1;
          end
        end
        plst_pkg::MODE_CLEAR: begin
          count_next = '0;
        end
        default: begin
          // Unused modes: no change, done.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells; each one shifts with its neighbors in the same cycle.
  for (genvar i = 0; i < plst_pkg::CAPACITY; i++) begin : g_cell
    plst_pkg::value_t left_nb;
    plst_pkg::value_t right_nb;

    if (i == 0) begin : g_first
      assign left_nb = '0;
    end else begin : g_mid_l
      assign left_nb = cell_data[i-1];
    end

    if (i == plst_pkg::CAPACITY - 1) begin : g_last
      assign right_nb = '0;
    end else begin : g_mid_r
      assign right_nb = cell_data[i+1];
    end

    plst_cell u_cell (
      .clk   (clk),
      .idx   (plst_pkg::IDX_W'(i)),
      .ctrl  (ctrl),
      .left  (left_nb),
      .right (right_nb),
      .data  (cell_data[i]),
      .rd    (cell_rd[i])
    );
  end

  // First level of the read-back: OR each group of cells.
  always_comb begin
    for (int g = 0; g < plst_pkg::NUM_GRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < plst_pkg::RD_GROUP; k++) begin
        if (g * plst_pkg::RD_GROUP + k < plst_pkg::CAPACITY) begin
          grp_next[g] = grp_next[g] | cell_rd[g * plst_pkg::RD_GROUP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (req_valid) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      s2_status <= status_next;
      s2_count  <= count_next;
      s2_get    <= get_ok;
      for (int g = 0; g < plst_pkg::NUM_GRP; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  // Second level of the read-back: OR the group registers.
  always_comb begin
    rd_all = '0;
    for (int g = 0; g < plst_pkg::NUM_GRP; g++) begin
      rd_all = rd_all | grp[g];
    end
  end

  assign s2_cnt_x = plst_pkg::CMP_W'(s2_count);

  // Result register: hold until the consumer takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s2_move) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      rsp.value_out <= s2_get ? rd_all : '0;
      rsp.status    <= s2_status;
      rsp.count     <= s2_cnt_x[plst_pkg::CNTO_W-1:0];
      rsp.is_empty  <= (s2_count == '0);
    end
  end

endmodule

// ===== rtl/core/plst_cell.sv =====
// ----------------------------------------------------------------------------
// plst_cell
// One entry of the list. Takes its left neighbor on insert, its right
// neighbor on remove, and drives its value onto the read bus when selected.
// ----------------------------------------------------------------------------
module plst_cell (
  input  logic                          clk,
  input  logic [plst_pkg::IDX_W-1:0]    idx,
  input  plst_pkg::cell_ctrl_t          ctrl,
  input  plst_pkg::value_t              left,
  input  plst_pkg::value_t              right,
  output plst_pkg::value_t              data,
  output plst_pkg::value_t              rd
);

  logic [plst_pkg::CMP_W-1:0] idx_x;
  logic                       at_pos;
  logic                       above_pos;

  assign idx_x     = plst_pkg::CMP_W'(idx);
  assign at_pos    = (idx_x == ctrl.pos);
  assign above_pos = (idx_x > ctrl.pos);

  always_ff @(posedge clk) begin
    if (ctrl.ins && above_pos) begin
      data <= left;
    end else if ((ctrl.ins || ctrl.wr) && at_pos) begin
      data <= ctrl.val;
    end else if (ctrl.rem && (at_pos || above_pos)) begin
      data <= right;
    end
  end

  assign rd = at_pos ? data : '0;

endmodule

// ===== tb/sv/positional_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Self-checking bench for the positional list store. A software copy of the
// list predicts the result of every request transfer. Results are compared
// field by field in order. Both handshakes idle and stall at random. There is
// one long result stall and several pauses that wait for the pipe to empty.
// ----------------------------------------------------------------------------
module positional_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plst_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 150;   // cycles the receiver holds off once
  localparam int HOLD_TRIGGER = 220;   // results checked before that hold
  localparam int TAIL_CYCLES  = 8;     // extra wait after the last result is back

  // Mode codes the block does not use; they must leave the list alone.
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_ALT = 32'sh5555_5555;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    value_t            value_in;
    bit                wait_drain;   // hold this request until nothing is due
  } list_request_t;

  typedef struct {
    value_t             value_out;
    logic [STAT_W-1:0]  status;
    logic [CNTO_W-1:0]  count;
    logic               is_empty;
  } list_reply_t;

  logic clk;
  logic rst;

  plst_req_if req ();
  plst_rsp_if rsp ();

  positional_list_store dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // List predictor: a plain array copy of the store and its length.
  // --------------------------------------------------------------------------
  value_t shadow_entries [CAPACITY];
  int     shadow_len;

  function automatic list_reply_t apply_request(list_request_t r);
    list_reply_t rep;
    int          p;
    rep.value_out = '0;
    rep.status    = ST_DONE;
    p = int'(r.position);
    case (r.mode)
      MODE_INSERT: begin
        if (p > shadow_len) begin
          rep.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          rep.status = ST_FULL;
        end else begin
          // open a slot at p by moving the tail up one place
          for (int i = shadow_len; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = r.value_in;
          shadow_len++;
        end
      end
      MODE_REMOVE: begin
        if (p >= shadow_len) begin
          rep.status = ST_RANGE;
        end else begin
          // close the gap at p by moving the tail down one place
          for (int i = p; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_len--;
        end
      end
      MODE_GET: begin
        if (p >= shadow_len) rep.status = ST_RANGE;
        else rep.value_out = shadow_entries[p];
      end
      MODE_SET: begin
        if (p >= shadow_len) rep.status = ST_RANGE;
        else shadow_entries[p] = r.value_in;
      end
      MODE_CLEAR: begin
        shadow_len = 0;
      end
      default: ;
    endcase
    rep.count    = CNTO_W'(shadow_len);
    rep.is_empty = (shadow_len == 0);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plan. plan_len tracks the list length the queued requests will
  // leave behind, so positions can be aimed at the live part of the list.
  // --------------------------------------------------------------------------
  list_request_t request_queue [$];
  list_reply_t   replies_due [$];
  int            plan_len;

  task automatic queue_request(logic [MODE_W-1:0] m, int p, value_t v, bit drain);
    list_request_t r;
    r.mode       = m;
    r.position   = POS_W'(p);
    r.value_in   = v;
    r.wait_drain = drain;
    request_queue = {request_queue, r};
    case (m)
      MODE_INSERT: if (p <= plan_len && plan_len < CAPACITY) plan_len++;
      MODE_REMOVE: if (p < plan_len) plan_len--;
      MODE_CLEAR:  plan_len = 0;
      default: ;
    endcase
  endtask

  // Mostly random words, with the extremes and zero mixed in now and then.
  function automatic value_t rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Aim inside the list most of the time; now and then anywhere in 0..64.
  function automatic int pick_position(bit for_insert);
    if ($urandom_range(0, 11) == 0) return $urandom_range(0, CAPACITY);
    if (for_insert) return $urandom_range(0, plan_len);
    if (plan_len == 0) return 0;
    return $urandom_range(0, plan_len - 1);
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. An
  // offered request is held until its transfer; a request marked to wait
  // for the drain is not offered until every due result has come back.
  // --------------------------------------------------------------------------
  list_request_t offered;
  int            burst_left;
  int            gap_left;
  int            issued;

  always @(posedge clk) begin
    if (rst) begin
      req.valid  <= 1'b0;
      shadow_len = 0;
      burst_left = 1;
      gap_left   = 0;
      issued     = 0;
    end else begin
      // predict the result of a transfer at this edge
      if (req.valid && req.ready) begin
        replies_due = {replies_due, apply_request(offered)};
        issued++;
      end
      if (req.valid && !req.ready) begin
        // hold the offered request until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (request_queue.size() != 0 &&
                   !(request_queue[0].wait_drain && replies_due.size() != 0)) begin
        offered = request_queue.pop_front();
        req.valid    <= 1'b1;
        req.mode     <= offered.mode;
        req.position <= offered.position;
        req.value_in <= offered.value_in;
        burst_left--;
        if (burst_left <= 0) begin
          // start a new burst; a quarter of the bursts run on with no gap
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check each transfer against the oldest prediction, and
  // drive ready from a rotating stall pattern that is reloaded each time its
  // window runs out. Once, after HOLD_TRIGGER results, hold ready low through the
  // LONG_HOLD stall so the block backs up and stalls its request side.
  // --------------------------------------------------------------------------
  int          mismatches;
  int          checked;
  int          range_hits;
  int          full_hits;
  int          hold_left;
  bit          long_hold_done;
  logic [15:0] ready_pattern;
  int          pattern_age;
  list_reply_t want;

  task automatic report_field(string field, logic signed [63:0] expected,
                              logic signed [63:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready      <= 1'b0;
      checked        = 0;
      range_hits     = 0;
      full_hits      = 0;
      hold_left      = 0;
      long_hold_done = 1'b0;
      pattern_age    = 0;
      ready_pattern  = '1;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result transfer with nothing due, value_out %0d status %0d count %0d",
                   $time, rsp.value_out, rsp.status, rsp.count);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          report_field("value_out", want.value_out, rsp.value_out);
          report_field("status", {62'd0, want.status}, {62'd0, rsp.status});
          report_field("count", {57'd0, want.count}, {57'd0, rsp.count});
          report_field("is_empty", {63'd0, want.is_empty}, {63'd0, rsp.is_empty});
          checked++;
          if (want.status == ST_RANGE) range_hits++;
          if (want.status == ST_FULL) full_hits++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (!long_hold_done && checked >= HOLD_TRIGGER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        rsp.ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          // a third of the windows never stall
          pattern_age   = 32;
          ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'($urandom));
        end
        pattern_age--;
        rsp.ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if it overstays the cycle limit.
  // --------------------------------------------------------------------------
  int cycles;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests queued and %0d results due",
               $time, request_queue.size(), replies_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int  kind;
    int  n;
    int  sel;
    int  random_queued;
    bit  first_seq;
    bit  drain;

    clk          = 1'b0;
    rst          = 1'b1;
    cycles       = 0;
    mismatches   = 0;
    req.valid    = 1'b0;
    req.mode     = '0;
    req.position = '0;
    req.value_in = '0;
    rsp.ready    = 1'b0;
    plan_len     = 0;

    // Directed: every operation on an empty list, then a short list built
    // with the extreme values, reads at both ends and past them, unused
    // modes, and a clear.
    queue_request(MODE_GET,    0,  '0, 1'b0);
    queue_request(MODE_REMOVE, 0,  '0, 1'b0);
    queue_request(MODE_SET,    0,  VAL_MAX, 1'b0);
    queue_request(MODE_CLEAR,  0,  '0, 1'b0);
    queue_request(MODE_INSERT, 1,  VAL_MAX, 1'b0);   // past the end
    queue_request(MODE_INSERT, 0,  VAL_MAX, 1'b0);
    queue_request(MODE_INSERT, 0,  VAL_MIN, 1'b0);
    queue_request(MODE_INSERT, 2,  -32'sd1, 1'b0);   // append
    queue_request(MODE_INSERT, 1,  '0, 1'b0);
    for (int i = 0; i < 4; i++) queue_request(MODE_GET, i, '0, 1'b0);
    queue_request(MODE_GET,    4,  '0, 1'b0);
    queue_request(MODE_GET,    CAPACITY, '0, 1'b0);
    queue_request(MODE_SET,    3,  VAL_ALT, 1'b0);
    queue_request(MODE_SET,    4,  VAL_MIN, 1'b0);
    queue_request(MODE_GET,    3,  '0, 1'b0);
    queue_request(MODE_REMOVE, 0,  '0, 1'b0);
    queue_request(MODE_REMOVE, 2,  '0, 1'b0);        // last entry
    queue_request(MODE_REMOVE, 2,  '0, 1'b0);        // now past the end
    queue_request(MODE_SPARE_A, CAPACITY, VAL_MIN, 1'b0);
    queue_request(MODE_SPARE_B, 0, VAL_MAX, 1'b0);
    queue_request(MODE_GET,    0,  '0, 1'b0);
    queue_request(MODE_GET,    1,  '0, 1'b0);
    queue_request(MODE_CLEAR,  0,  '0, 1'b0);
    queue_request(MODE_GET,    0,  '0, 1'b0);

    // Random: fill runs that end in inserts on a full list, drain runs that
    // hold one remove more than the list holds, and mixed runs aimed mostly inside
    // the list. The first run is a fill and waits for the pipe to empty.
    random_queued = 0;
    first_seq     = 1'b1;
    while (random_queued < RANDOM_ITEMS) begin
      kind      = first_seq ? 0 : $urandom_range(0, 11);
      drain     = first_seq || ($urandom_range(0, 7) == 0);
      first_seq = 1'b0;
      if (kind == 0) begin
        n = CAPACITY - plan_len + $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          if (plan_len >= CAPACITY && k == n - 1)
            queue_request(MODE_INSERT, CAPACITY, rand_value(), 1'b0);
          else
            queue_request(MODE_INSERT, $urandom_range(0, plan_len), rand_value(),
                          drain && k == 0);
        end
      end else if (kind == 1) begin
        n = plan_len + 1;
        for (int k = 0; k < n; k++)
          queue_request(MODE_REMOVE, pick_position(1'b0), '0, drain && k == 0);
      end else begin
        n = $urandom_range(8, 20);
        for (int k = 0; k < n; k++) begin
          sel = $urandom_range(0, 99);
          if (sel < 30)
            queue_request(MODE_INSERT, pick_position(1'b1), rand_value(), drain && k == 0);
          else if (sel < 50)
            queue_request(MODE_REMOVE, pick_position(1'b0), rand_value(), drain && k == 0);
          else if (sel < 75)
            queue_request(MODE_GET, pick_position(1'b0), rand_value(), drain && k == 0);
          else if (sel < 94)
            queue_request(MODE_SET, pick_position(1'b0), rand_value(), drain && k == 0);
          else if (sel < 97)
            queue_request(MODE_CLEAR, $urandom_range(0, CAPACITY), rand_value(),
                          drain && k == 0);
          else
            queue_request(MODE_GET, $urandom_range(0, CAPACITY), '0, drain && k == 0);
        end
      end
      random_queued += n;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // advance until every request is taken and every result is back
    while (request_queue.size() != 0 || req.valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (replies_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, replies_due.size());
      mismatches++;
    end

    $display("Covered %0d requests and checked %0d results, %0d out of range, %0d list full.",
             issued, checked, range_hits, full_hits);
    $display("Long result stall taken: %0d, mismatches: %0d.", long_hold_done, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
